// ----- rtl/core/swtm_pkg.sv -----
// shared types and constants for the sliding window throughput meter
package swtm_pkg;

   typedef enum logic [2:0] {
      CMD_UNIT  = 3'd0,
      CMD_TICK  = 3'd1,
      CMD_TRAYS = 3'd2,
      CMD_TRAYE = 3'd3,
      CMD_CLEAR = 3'd4
   } cmd_type;

   localparam logic [0:0] CSR_WINDOW = 1'b0;
   localparam logic [0:0] CSR_TOTAL  = 1'b1;

   localparam logic [11:0] WIN_DEFAULT = 12'd600;
   localparam logic [11:0] WIN_MIN     = 12'd30;
   localparam logic [11:0] WIN_MAX     = 12'd3600;
   localparam logic [21:0] RATE_FIELD_MAX = 22'h3FFFFF;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [9:0]  MS_PER_SEC = 10'd1000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UNIT_RD,
      ST_UNIT_WR,
      ST_SEC_NOW,
      ST_TICK_RD,
      ST_TICK_WAIT,
      ST_TICK_SEC,
      ST_TICK_CMP,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;       // capture input transaction
      logic unit_rd;    // read newest entry
      logic unit_wr;    // store timestamp, count unit
      logic sec_now;    // start seconds conversion of now
      logic head_rd;    // read oldest entry
      logic sec_head;   // start seconds conversion of head
      logic cmp;        // drop or keep decision
      logic div_start;  // start rate divide
      logic simple;     // tray, clear and unknown commands
      logic out_load;   // publish result
   } cmd_bus_type;

   typedef struct packed {
      logic sec_done;
      logic drop;       // head older than window
      logic empty;
      logic div_done;
   } sts_bus_type;

endpackage

// ----- rtl/core/swtm_ctrl.sv -----
// controller state machine for the throughput meter
module swtm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_cmd,
   input  logic                  rsp_busy,
   input  swtm_pkg::sts_bus_type sts,
   output swtm_pkg::cmd_bus_type cmd
);

   swtm_pkg::state_type state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swtm_pkg::ST_IDLE;
         cmd_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      unique case (state_ff)
         swtm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_cmd;
               priority case (req_cmd)
                  swtm_pkg::CMD_UNIT: state_in = swtm_pkg::ST_UNIT_RD;
                  swtm_pkg::CMD_TICK: state_in = swtm_pkg::ST_SEC_NOW;
                  default:            state_in = swtm_pkg::ST_OUT;
               endcase
            end
         end
         swtm_pkg::ST_UNIT_RD: state_in = swtm_pkg::ST_UNIT_WR;
         swtm_pkg::ST_UNIT_WR: state_in = swtm_pkg::ST_OUT;
         swtm_pkg::ST_SEC_NOW:
            if (sts.sec_done) state_in = swtm_pkg::ST_TICK_RD;
         swtm_pkg::ST_TICK_RD:
            state_in = sts.empty ? swtm_pkg::ST_DIV : swtm_pkg::ST_TICK_WAIT;
         swtm_pkg::ST_TICK_WAIT: state_in = swtm_pkg::ST_TICK_SEC;
         swtm_pkg::ST_TICK_SEC:
            if (sts.sec_done) state_in = swtm_pkg::ST_TICK_CMP;
         swtm_pkg::ST_TICK_CMP:
            state_in = sts.drop ? swtm_pkg::ST_TICK_RD : swtm_pkg::ST_DIV;
         swtm_pkg::ST_DIV:
            if (sts.div_done) state_in = swtm_pkg::ST_OUT;
         swtm_pkg::ST_OUT:
            if (!rsp_busy) state_in = swtm_pkg::ST_IDLE;
         default: state_in = swtm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = (state_ff == swtm_pkg::ST_IDLE);
      unique case (state_ff)
         swtm_pkg::ST_IDLE:      cmd.load = req_tvalid;
         swtm_pkg::ST_UNIT_RD:   cmd.unit_rd = 1'b1;
         swtm_pkg::ST_UNIT_WR:   cmd.unit_wr = 1'b1;
         swtm_pkg::ST_SEC_NOW:   cmd.sec_now = 1'b1;
         swtm_pkg::ST_TICK_RD:   begin
            cmd.head_rd = 1'b1;
            cmd.div_start = sts.empty;
         end
         swtm_pkg::ST_TICK_SEC:  cmd.sec_head = 1'b1;
         swtm_pkg::ST_TICK_CMP:  begin
            cmd.cmp = 1'b1;
            cmd.div_start = !sts.drop;
         end
         swtm_pkg::ST_OUT: begin
            cmd.out_load = !rsp_busy;
            cmd.simple = !rsp_busy && (cmd_ff != swtm_pkg::CMD_UNIT)
                         && (cmd_ff != swtm_pkg::CMD_TICK);
         end
         default: ;
      endcase
   end

endmodule

// ----- rtl/core/swtm_sec.sv -----
// milliseconds to seconds by multiplying with a scaled reciprocal of 1000
module swtm_sec (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] ms,
   output logic        done,
   output logic [38:0] sec
);

   // ms / 1000 = (ms >> 3) / 125 = ((ms >> 3) * RECIP) >> 52, exact for 45 bit operands
   localparam logic [45:0] RECIP = 46'd36028797018964;

   logic [44:0] x_ff, x_in;
   logic [91:0] acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [22:0] op_a, op_b;
   logic [45:0] prod;
   logic [91:0] prod_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   // one 23 by 23 partial product a cycle
   assign op_a = step_ff[1] ? {1'b0, x_ff[44:23]} : x_ff[22:0];
   assign op_b = step_ff[0] ? RECIP[45:23] : RECIP[22:0];
   assign prod = op_a * op_b;

   always_comb begin
      unique case (step_ff)
         2'd0:       prod_sh = {46'd0, prod};
         2'd1, 2'd2: prod_sh = {23'd0, prod, 23'd0};
         2'd3:       prod_sh = {prod, 46'd0};
      endcase
   end

   always_comb begin
      x_in    = x_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start && !busy_ff) begin
         x_in    = ms[47:3];
         acc_in  = '0;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = acc_ff + prod_sh;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) busy_in = 1'b0;
      end
   end

   assign done = busy_ff && (step_ff == 2'd3);
   assign sec  = acc_in[90:52];

endmodule

// ----- rtl/core/swtm_div.sv -----
// iterative rate divider, one quotient bit a cycle
module swtm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [27:0] num,
   input  logic [38:0] den,
   output logic        done,
   output logic [27:0] quo
);

   logic [27:0] quo_ff, quo_in;
   logic [38:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [39:0] trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   logic [38:0] den_ff, den_in;
   always_ff @(posedge clock) den_ff <= den_in;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[27]};
      if (start && !busy_ff) begin
         quo_in  = num;
         rem_in  = 39'd0;
         den_in  = den;
         cnt_in  = 5'd28;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 39'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[26:0], 1'b1};
         end else begin
            rem_in = trial[38:0];
            quo_in = {quo_ff[26:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   assign done = busy_ff && (cnt_ff == 5'd1);
   assign quo  = quo_in;

endmodule

// ----- rtl/core/swtm_dp.sv -----
// datapath: timestamp memory, counters, time registers and arithmetic
module swtm_dp #(
   parameter int FIFO_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            req_cmd,
   input  logic [47:0]           req_now_ms,
   input  logic                  csr_wen,
   input  logic [0:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  swtm_pkg::cmd_bus_type cmd,
   output swtm_pkg::sts_bus_type sts,
   output logic                  rsp_load,
   output logic [21:0]           rate_out,
   output logic [31:0]           total_out,
   output logic [48:0]           cycle_out,
   output logic [48:0]           tray_out,
   output logic [10:0]           count_out,
   output logic                  ovf_out
);

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
   localparam longint RMAX_L = (longint'(FIFO_DEPTH) * 3600 > 4194303)
                               ? 4194303 : longint'(FIFO_DEPTH) * 3600;
   localparam logic [21:0] RATE_MAX = 22'(RMAX_L);

   logic [47:0] mem [FIFO_DEPTH];
   logic [47:0] rd_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;

   logic [2:0]    cmd_ff;
   logic [47:0]   now_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [21:0]   rate_ff, rate_in;
   logic [31:0]   total_ff, total_in;
   logic [48:0]   cycle_ff, cycle_in, tray_ff, tray_in;
   logic [47:0]   tstart_ff, tstart_in;
   logic [11:0]   win_ff;
   logic          ovf_ff, ovf_in;
   logic [38:0]   now_s_ff;
   logic [39:0]   diff_ff;
   logic          sec_start, sec_done;
   logic [38:0]   sec_val;
   logic [47:0]   sec_src;
   logic          div_done;
   logic [27:0]   div_q;
   logic [39:0]   diff_now;
   logic [11:0]   win_eff;
   logic          div_sat, div_zero;
   logic          div_run_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= now_ff;
      rd_ff <= mem[rd_addr];
   end

   assign rd_addr = cmd.unit_rd ? AW'(head_ff + AW'(count_ff - CW'(1))) : head_ff;
   assign wr_addr = AW'(head_in + AW'(count_in - CW'(1)));
   assign wr_en   = cmd.unit_wr;

   assign win_eff = (win_ff < swtm_pkg::WIN_MIN || win_ff > swtm_pkg::WIN_MAX)
                    ? swtm_pkg::WIN_DEFAULT : win_ff;

   assign sec_start = cmd.sec_now || cmd.sec_head;
   assign sec_src   = cmd.sec_now ? now_ff : rd_ff;
   swtm_sec u_sec (
      .clock (clock), .reset (reset), .start (sec_start), .ms (sec_src),
      .done (sec_done), .sec (sec_val)
   );

   logic [38:0] head_s_ff;
   always_ff @(posedge clock) begin
      if (sec_done && cmd.sec_now) now_s_ff <= sec_val;
      if (sec_done && cmd.sec_head) head_s_ff <= sec_val;
   end
   assign diff_now = 40'({1'b0, now_s_ff} - {1'b0, head_s_ff});

   assign sts.sec_done = sec_done;
   assign sts.empty    = (count_ff == '0);
   assign sts.drop     = !diff_now[39] && (diff_now > 40'(win_eff));
   assign sts.div_done = div_done || (div_run_ff && (div_zero || div_sat));

   assign div_zero = (count_ff == '0);
   assign div_sat  = diff_ff[39] || (diff_ff == '0);

   swtm_div u_div (
      .clock (clock), .reset (reset),
      .start (cmd.div_start && !sts.empty && !diff_now[39] && (diff_now != '0)),
      .num   (28'(count_ff) * 28'(swtm_pkg::SECS_PER_HOUR)),
      .den   (diff_now[38:0]),
      .done  (div_done), .quo (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff     <= 3'd0;
         head_ff    <= '0;
         count_ff   <= '0;
         rate_ff    <= 22'd0;
         total_ff   <= 32'd0;
         cycle_ff   <= '1;
         tray_ff    <= '1;
         tstart_ff  <= 48'd0;
         win_ff     <= swtm_pkg::WIN_DEFAULT;
         ovf_ff     <= 1'b0;
         div_run_ff <= 1'b0;
      end else begin
         if (cmd.load) cmd_ff <= req_cmd;
         head_ff   <= head_in;
         count_ff  <= count_in;
         rate_ff   <= rate_in;
         total_ff  <= total_in;
         cycle_ff  <= cycle_in;
         tray_ff   <= tray_in;
         tstart_ff <= tstart_in;
         ovf_ff    <= ovf_in;
         if (cmd.div_start) div_run_ff <= 1'b1;
         else if (sts.div_done) div_run_ff <= 1'b0;
         if (csr_wen && csr_index == swtm_pkg::CSR_WINDOW) win_ff <= csr_wdata[11:0];
      end
      if (cmd.load) now_ff <= req_now_ms;
      if (cmd.div_start) diff_ff <= diff_now;
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      rate_in   = rate_ff;
      total_in  = total_ff;
      cycle_in  = cycle_ff;
      tray_in   = tray_ff;
      tstart_in = tstart_ff;
      ovf_in    = ovf_ff;
      if (cmd.load) ovf_in = 1'b0;
      if (cmd.unit_wr) begin
         if (count_ff != '0)
            cycle_in = 49'({1'b0, now_ff} - {1'b0, rd_ff});
         if (count_ff >= DEPTH_C) begin
            head_in  = AW'(head_ff + AW'(1));
            count_in = DEPTH_C;
            ovf_in   = 1'b1;
         end else begin
            count_in = CW'(count_ff + CW'(1));
         end
         if (total_ff != 32'hFFFF_FFFF) total_in = total_ff + 32'd1;
      end
      if (cmd.cmp && sts.drop) begin
         head_in  = AW'(head_ff + AW'(1));
         count_in = CW'(count_ff - CW'(1));
      end
      if (div_run_ff) begin
         if (div_zero) rate_in = 22'd0;
         else if (div_sat) rate_in = RATE_MAX;
         else if (div_done)
            rate_in = (div_q > 28'(RATE_MAX)) ? RATE_MAX : div_q[21:0];
      end
      if (cmd.simple) begin
         unique case (cmd_ff)
            swtm_pkg::CMD_TRAYS: tstart_in = now_ff;
            swtm_pkg::CMD_TRAYE: tray_in = 49'({1'b0, now_ff} - {1'b0, tstart_ff});
            swtm_pkg::CMD_CLEAR: begin
               head_in  = '0;
               count_in = '0;
               rate_in  = 22'd0;
               cycle_in = '1;
               tray_in  = '1;
               total_in = 32'd0;
            end
            default: ;
         endcase
      end
      if (csr_wen && csr_index == swtm_pkg::CSR_TOTAL) total_in = csr_wdata;
   end

   assign rsp_load  = cmd.out_load;
   assign rate_out  = rate_ff;
   assign total_out = total_ff;
   assign cycle_out = cycle_ff;
   assign tray_out  = tray_ff;
   assign count_out = 11'(count_ff);
   assign ovf_out   = ovf_ff;

endmodule

// ----- rtl/core/sliding_window_throughput_meter.sv -----
// top level of the sliding window throughput meter
// usage:
//   req channel carries one transaction per event: tdata = {now_ms, cmd}
//   (cmd unit done, compute tick, tray start, tray end, clear).
//   rsp channel returns one transaction per request with the current rate,
//   total, cycle time, tray time, window count and overflow flag.
//   csr port writes window_seconds (index 0) or start_total (index 1), which loads
//   the total; the user writes only while the block is idle (not enforced).
// sequence of work per command, from acceptance to rsp_tvalid:
//   tray, clear and unknown commands go straight to publish; unit done reads the
//   newest entry, then stores the timestamp. compute tick converts now to seconds,
//   then inspects entries from the oldest (memory read, a wait state, a reciprocal
//   multiply seconds conversion, compare), then runs the bit-serial rate divide
//   (skipped when the window empties or the rate saturates), then publishes; the
//   entry loop sets the worst case.
//   one request is processed at a time; the next is taken as the result appears.
// reset: window 600 s, total 0, times -1, window empty; no clearing pass.
// stall: the result waits in the output register; the next request is
//   taken and run while it waits, and holds until the register frees.
module sliding_window_throughput_meter #(
   parameter int FIFO_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // cmd[2:0], now_ms[50:3], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata,   // units_per_hour, total_units, last_cycle_ms,
                                     // tray_time_ms, window_count, overflow, zero pad
   input  logic         csr_wen,
   input  logic [0:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   swtm_pkg::cmd_bus_type cmd;
   swtm_pkg::sts_bus_type sts;
   logic rsp_load;
   logic [21:0] rate;
   logic [31:0] total;
   logic [48:0] cyc, tray;
   logic [10:0] cnt;
   logic ovf;
   logic rsp_valid_ff, rsp_valid_in;
   logic load_d_ff;
   logic [163:0] rsp_data_ff;

   swtm_ctrl u_ctrl (
      .clock (clock), .reset (reset),
      .req_tvalid (req_tvalid), .req_tready (req_tready),
      .req_cmd (req_tdata[2:0]),
      .rsp_busy (load_d_ff || (rsp_valid_ff && !rsp_tready)),
      .sts (sts), .cmd (cmd)
   );

   swtm_dp #(.FIFO_DEPTH (FIFO_DEPTH)) u_dp (
      .clock (clock), .reset (reset),
      .req_cmd (req_tdata[2:0]), .req_now_ms (req_tdata[50:3]),
      .csr_wen (csr_wen), .csr_index (csr_index), .csr_wdata (csr_wdata),
      .cmd (cmd), .sts (sts), .rsp_load (rsp_load),
      .rate_out (rate), .total_out (total), .cycle_out (cyc),
      .tray_out (tray), .count_out (cnt), .ovf_out (ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) load_d_ff <= 1'b0;
      else       load_d_ff <= rsp_load;
   end

   assign rsp_valid_in = load_d_ff || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // state registers settle in the cycle after the publish command
   always_ff @(posedge clock) begin
      if (load_d_ff) rsp_data_ff <= {ovf, cnt, tray, cyc, total, rate};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the sliding window throughput meter
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIFO_DEPTH = 1024;
   localparam longint RATE_TOP = 3686400;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic        overflow;
      logic [10:0] window_count;
      logic [48:0] tray_time_ms;
      logic [48:0] last_cycle_ms;
      logic [31:0] total_units;
      logic [21:0] units_per_hour;
   } meter_report_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  req_tdata;   // cmd[2:0], now_ms[50:3], zero pad
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [167:0] rsp_tdata;   // units_per_hour, total_units, last_cycle_ms,
                              // tray_time_ms, window_count, overflow, zero pad
   logic         csr_wen;
   logic [0:0]   csr_index;
   logic [31:0]  csr_wdata;

   sliding_window_throughput_meter #(.FIFO_DEPTH(FIFO_DEPTH)) uut (.*);

   // predictor state
   logic [47:0] stamp_mem [FIFO_DEPTH];
   int          head_ptr;
   int          stamp_count;
   longint      rate_now;
   longint      total_now;
   longint      cycle_ms;
   longint      tray_ms;
   longint      tray_start_ms;
   longint      window_reg;

   meter_report_type pending_reports[$];
   int  src_idle_pct;
   int  snk_idle_pct;
   int  error_count;
   int  checked_count;
   int  overflow_seen;
   int  full_rate_seen;
   longint cycle_count;
   longint clock_ms;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic meter_report_type meter_predict(logic [2:0] cmd, logic [47:0] now);
      meter_report_type r;
      longint now_s, win, gap, q;
      logic ovf;
      ovf = 1'b0;
      case (cmd)
         swtm_pkg::CMD_UNIT: begin
            if (stamp_count > 0)
               cycle_ms = longint'(now)
                  - longint'(stamp_mem[(head_ptr + stamp_count - 1) % FIFO_DEPTH]);
            if (stamp_count >= FIFO_DEPTH) begin
               head_ptr = (head_ptr + 1) % FIFO_DEPTH;
               stamp_count = FIFO_DEPTH - 1;
               ovf = 1'b1;
            end
            stamp_mem[(head_ptr + stamp_count) % FIFO_DEPTH] = now;
            stamp_count++;
            if (total_now != 64'hFFFFFFFF) total_now++;
         end
         swtm_pkg::CMD_TICK: begin
            now_s = longint'(now) / 1000;
            win = (window_reg < 30 || window_reg > 3600) ? 600 : window_reg;
            gap = 0;
            while (stamp_count > 0) begin
               gap = now_s - longint'(stamp_mem[head_ptr]) / 1000;
               if (gap > win) begin
                  head_ptr = (head_ptr + 1) % FIFO_DEPTH;
                  stamp_count--;
               end else break;
            end
            if (stamp_count == 0) rate_now = 0;
            else if (gap <= 0) rate_now = RATE_TOP;
            else begin
               q = longint'(stamp_count) * 3600 / gap;
               rate_now = (q > RATE_TOP) ? RATE_TOP : q;
            end
         end
         swtm_pkg::CMD_TRAYS: tray_start_ms = longint'(now);
         swtm_pkg::CMD_TRAYE: tray_ms = longint'(now) - tray_start_ms;
         swtm_pkg::CMD_CLEAR: begin
            head_ptr = 0;
            stamp_count = 0;
            rate_now = 0;
            cycle_ms = -1;
            tray_ms = -1;
            total_now = 0;
         end
         default: ;
      endcase
      r.units_per_hour = rate_now[21:0];
      r.total_units = total_now[31:0];
      r.last_cycle_ms = cycle_ms[48:0];
      r.tray_time_ms = tray_ms[48:0];
      r.window_count = stamp_count[10:0];
      r.overflow = ovf;
      return r;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_event(logic [2:0] cmd, logic [47:0] now);
      meter_report_type r;
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, now, cmd};
      r = meter_predict(cmd, now);
      if (r.overflow) overflow_seen++;
      if (cmd == swtm_pkg::CMD_TICK && r.units_per_hour == RATE_TOP[21:0]) full_rate_seen++;
      pending_reports.push_back(r);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [31:0] value);
      wait_idle();
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == swtm_pkg::CSR_WINDOW) window_reg = value[11:0];
      else begin
         total_now = value;
      end
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_event();
      int pick;
      logic [2:0] cmd;
      pick = $urandom_range(99);
      if (pick < 50) cmd = swtm_pkg::CMD_UNIT;
      else if (pick < 75) cmd = swtm_pkg::CMD_TICK;
      else if (pick < 84) cmd = swtm_pkg::CMD_TRAYS;
      else if (pick < 93) cmd = swtm_pkg::CMD_TRAYE;
      else if (pick < 96) cmd = swtm_pkg::CMD_CLEAR;
      else cmd = 3'($urandom_range(7, 5));
      pick = $urandom_range(99);
      if (pick < 10) clock_ms += 0;
      else if (pick < 80) clock_ms += $urandom_range(3000);
      else if (pick < 95) clock_ms += $urandom_range(60000);
      else clock_ms += $urandom_range(4000000);
      send_event(cmd, clock_ms[47:0]);
   endtask

   task automatic test_directed();
      src_idle_pct = 0;
      snk_idle_pct = 0;
      send_event(swtm_pkg::CMD_TRAYE, 48'd5000);      // tray end without start
      send_event(swtm_pkg::CMD_TICK, 48'd0);          // empty window
      send_event(swtm_pkg::CMD_UNIT, 48'd0);
      send_event(swtm_pkg::CMD_TICK, 48'd999);        // same second as oldest
      send_event(swtm_pkg::CMD_UNIT, 48'd1500);
      send_event(swtm_pkg::CMD_TICK, 48'd2000);
      send_event(swtm_pkg::CMD_UNIT, 48'd1000);       // time going backwards
      send_event(swtm_pkg::CMD_TICK, 48'd500);
      send_event(swtm_pkg::CMD_TRAYS, 48'd7000);
      send_event(swtm_pkg::CMD_TRAYE, 48'd6000);
      send_event(3'd5, 48'hFFFFFFFFFFFF);
      send_event(3'd6, 48'd0);
      send_event(3'd7, 48'hAAAAAAAAAAAA);
      send_event(swtm_pkg::CMD_TICK, 48'd900000);     // drop everything
      send_event(swtm_pkg::CMD_UNIT, 48'hFFFFFFFFFFFF);
      send_event(swtm_pkg::CMD_UNIT, 48'h555555555555);
      send_event(swtm_pkg::CMD_TICK, 48'hFFFFFFFFFFFF);
      send_event(swtm_pkg::CMD_TRAYS, 48'hFFFFFFFFFFFF);
      send_event(swtm_pkg::CMD_TRAYE, 48'd0);
      send_event(swtm_pkg::CMD_CLEAR, 48'd123);
      send_event(swtm_pkg::CMD_TRAYE, 48'hFFFFFFFFFFFF);
   endtask

   task automatic test_total_saturation();
      write_csr(swtm_pkg::CSR_TOTAL, 32'hFFFFFFFE);
      repeat (3) send_event(swtm_pkg::CMD_UNIT, 48'd10000);
      write_csr(swtm_pkg::CSR_TOTAL, 32'd0);
      send_event(swtm_pkg::CMD_UNIT, 48'd11000);
      send_event(swtm_pkg::CMD_CLEAR, 48'd12000);
   endtask

   task automatic test_fifo_overflow();
      clock_ms = 20000;
      for (int i = 0; i < FIFO_DEPTH + 8; i++) begin
         clock_ms += $urandom_range(20);
         send_event(swtm_pkg::CMD_UNIT, clock_ms[47:0]);
      end
      send_event(swtm_pkg::CMD_TICK, clock_ms[47:0]);
      clock_ms += 4000000;
      send_event(swtm_pkg::CMD_TICK, clock_ms[47:0]);
   endtask

   task automatic test_random_phase(int src_pct, int snk_pct, logic [11:0] win, int n);
      src_idle_pct = 0;
      snk_idle_pct = 0;
      write_csr(swtm_pkg::CSR_WINDOW, {20'd0, win});
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      for (int i = 0; i < n; i++) send_random_event();
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= snk_idle_pct);

   always @(posedge clock) begin
      meter_report_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[163:0];
         checked_count++;
         if (pending_reports.size() == 0) begin
            $error("unexpected result transaction %h", got);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (got.units_per_hour !== want.units_per_hour) begin
               $error("units_per_hour exp %0d got %0d", want.units_per_hour,
                  got.units_per_hour);
               error_count++;
            end
            if (got.total_units !== want.total_units) begin
               $error("total_units exp %0d got %0d", want.total_units, got.total_units);
               error_count++;
            end
            if (got.last_cycle_ms !== want.last_cycle_ms) begin
               $error("last_cycle_ms exp %h got %h", want.last_cycle_ms,
                  got.last_cycle_ms);
               error_count++;
            end
            if (got.tray_time_ms !== want.tray_time_ms) begin
               $error("tray_time_ms exp %h got %h", want.tray_time_ms, got.tray_time_ms);
               error_count++;
            end
            if (got.window_count !== want.window_count) begin
               $error("window_count exp %0d got %0d", want.window_count,
                  got.window_count);
               error_count++;
            end
            if (got.overflow !== want.overflow) begin
               $error("overflow exp %0d got %0d", want.overflow, got.overflow);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_reports.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      overflow_seen = 0;
      full_rate_seen = 0;
      src_idle_pct = 0;
      snk_idle_pct = 0;
      head_ptr = 0;
      stamp_count = 0;
      rate_now = 0;
      total_now = 0;
      cycle_ms = -1;
      tray_ms = -1;
      tray_start_ms = 0;
      window_reg = 600;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_total_saturation();
      test_fifo_overflow();
      clock_ms = 100000;
      test_random_phase(0, 0, 12'd30, 200);
      clock_ms = longint'({$urandom, $urandom}) & 64'h7FFFFFFFFFFF;
      test_random_phase(79, 0, 12'd3600, 200);
      write_csr(swtm_pkg::CSR_TOTAL, $urandom);
      test_random_phase(0, 79, 12'd29, 200);
      test_random_phase(16, 16, 12'd4095, 120);
      test_random_phase(0, 0, 12'(
         $urandom_range(3600, 30)), 80);
      test_random_phase(16, 16, 12'd0, 80);

      wait_idle();
      repeat (100) @(negedge clock);
      $display("checked %0d results over all commands, window and total settings",
         checked_count);
      $display("fifo overflows %0d, saturated rate ticks %0d", overflow_seen,
         full_rate_seen);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ----- sliding_window_throughput_meter.f -----
rtl/core/swtm_pkg.sv
rtl/core/swtm_ctrl.sv
rtl/core/swtm_sec.sv
rtl/core/swtm_div.sv
rtl/core/swtm_dp.sv
rtl/core/sliding_window_throughput_meter.sv
verif/tb_top.sv
